FILE: rtl/paf_pkg.sv
// paf_pkg: shared types, codes and filter arithmetic for the adaptive png row filter
// no dependencies; imported by paf_ctrl, paf_datapath and png_adaptive_row_filter
package paf_pkg;

  localparam int ROW_LEN_W   = 13;
  localparam int BPP_W       = 3;
  localparam int FLT_W       = 3;
  localparam int NUM_FILTERS = 5;

  localparam logic [BPP_W-1:0] BPP_MIN = 3'd1;
  localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

  localparam logic [FLT_W-1:0] FLT_NONE  = 3'd0;
  localparam logic [FLT_W-1:0] FLT_SUB   = 3'd1;
  localparam logic [FLT_W-1:0] FLT_UP    = 3'd2;
  localparam logic [FLT_W-1:0] FLT_AVG   = 3'd3;
  localparam logic [FLT_W-1:0] FLT_PAETH = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOTHING = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_BPP        = 1'b1;

  typedef logic [7:0] pix_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic commit;
    logic select;
  } paf_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic row_end;
  } paf_sts_t;

  function automatic pix_t paeth_pred(input pix_t a, input pix_t b, input pix_t c);
    logic signed [10:0] sa, sb, sc, p, pa, pb, pc;
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    p  = sa + sb - sc;
    pa = p - sa;
    pb = p - sb;
    pc = p - sc;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    else if (pb <= pc) return b;
    else return c;
  endfunction

  function automatic pix_t filter_residue(input logic [FLT_W-1:0] f, input pix_t x,
                                          input pix_t a, input pix_t b, input pix_t c);
    pix_t pr;
    logic [8:0] avg;
    avg = {1'b0, a} + {1'b0, b};
    case (f)
      FLT_NONE:  pr = '0;
      FLT_SUB:   pr = a;
      FLT_UP:    pr = b;
      FLT_AVG:   pr = avg[8:1];
      FLT_PAETH: pr = paeth_pred(a, b, c);
      default:   pr = '0;
    endcase
    return x - pr;
  endfunction

  // absolute value of the residue taken as a signed byte
  function automatic pix_t residue_mag(input pix_t r);
    return r[7] ? (~r + 8'd1) : r;
  endfunction

endpackage

FILE: rtl/paf_ctrl.sv
// paf_ctrl: sequencer for the adaptive png row filter
// depends on paf_pkg; drives paf_datapath through paf_cmd_t, watches paf_sts_t
module paf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  paf_pkg::paf_sts_t  sts,
  output paf_pkg::paf_cmd_t  cmd
);
  import paf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_SELECT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_busy) state_next = sts.row_end ? S_SELECT : S_IDLE;
      end
      S_SELECT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_ready  = (state == S_IDLE);
  assign cmd.accept = (state == S_IDLE) && req_valid;
  assign cmd.eval   = (state == S_EVAL);
  assign cmd.commit = (state == S_COMMIT) && !sts.out_busy;
  assign cmd.select = (state == S_SELECT);

endmodule

FILE: rtl/paf_datapath.sv
// paf_datapath: row memories, five residue units, running sums and output register
// depends on paf_pkg; sequenced by paf_ctrl
module paf_datapath #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  paf_pkg::paf_cmd_t               cmd,
  output paf_pkg::paf_sts_t               sts,
  input  logic [paf_pkg::ROW_LEN_W-1:0]   row_length,
  input  logic [paf_pkg::BPP_W-1:0]       bytes_per_pixel,
  input  logic                            req_type,
  input  logic [7:0]                      data_byte,
  input  logic                            new_image,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [7:0]                      out_byte,
  output logic                            row_last,
  output logic [1:0]                      status
);
  import paf_pkg::*;

  localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int LEN_W  = (POS_W > ROW_LEN_W) ? POS_W : ROW_LEN_W;
  localparam int IB_W   = (ADDR_W > BPP_W) ? ADDR_W : BPP_W;
  localparam int SUM_W  = $clog2(128 * MAX_ROW_BYTES + 1);

  // two banks swap roles of current and previous row
  pix_t mem0 [MAX_ROW_BYTES];
  pix_t mem1 [MAX_ROW_BYTES];
  pix_t m0_x, m0_l, m1_x, m1_l;

  logic                bank;
  logic                has_prev;
  logic                pending;
  logic [POS_W-1:0]    wpos;
  logic [POS_W-1:0]    rpos;
  logic [SUM_W-1:0]    sums [NUM_FILTERS];
  logic [FLT_W-1:0]    chosen;

  logic                wr_q;
  pix_t                data_q;
  logic                newimg_q;
  logic [1:0]          st_q;
  logic [ADDR_W-1:0]   idx_q;
  logic                left_q;
  logic                hp_q;

  pix_t                res_q [NUM_FILTERS];
  logic                row_end_q;

  // address generation at accept
  logic                is_wr;
  logic [BPP_W-1:0]    bpp_eff;
  logic [ADDR_W-1:0]   pos_w, pos_r, rd_i, rd_l;
  logic [POS_W-1:0]    rpos_m1;
  logic                rd_left;

  always_comb begin
    is_wr = (req_type == REQ_WRITE);
    if (bytes_per_pixel < BPP_MIN)      bpp_eff = BPP_MIN;
    else if (bytes_per_pixel > BPP_MAX) bpp_eff = BPP_MAX;
    else                                bpp_eff = bytes_per_pixel;
    if (new_image)                              pos_w = '0;
    else if (wpos >= POS_W'(MAX_ROW_BYTES))     pos_w = ADDR_W'(MAX_ROW_BYTES - 1);
    else                                        pos_w = ADDR_W'(wpos);
    rpos_m1 = rpos - POS_W'(1);
    pos_r   = ADDR_W'(rpos_m1);
    rd_i    = is_wr ? pos_w : pos_r;
    rd_left = IB_W'(rd_i) >= IB_W'(bpp_eff);
    rd_l    = rd_left ? ADDR_W'(IB_W'(rd_i) - IB_W'(bpp_eff)) : '0;
  end

  // residues
  pix_t cur_x, cur_l, prv_x, prv_l, fa, fb, fc, fx;
  pix_t res [NUM_FILTERS];
  logic [POS_W-1:0] nxt_pos;
  logic [LEN_W-1:0] len_raw, len_eff;

  always_comb begin
    cur_x = bank ? m1_x : m0_x;
    cur_l = bank ? m1_l : m0_l;
    prv_x = bank ? m0_x : m1_x;
    prv_l = bank ? m0_l : m1_l;
    fa    = left_q ? cur_l : '0;
    fb    = hp_q ? prv_x : '0;
    fc    = (left_q && hp_q) ? prv_l : '0;
    fx    = wr_q ? data_q : cur_x;
    for (int f = 0; f < NUM_FILTERS; f++) begin
      res[f] = filter_residue(FLT_W'(f), fx, fa, fb, fc);
    end
    nxt_pos = POS_W'(idx_q) + POS_W'(1);
    len_raw = LEN_W'(row_length);
    if (len_raw == '0)                           len_eff = LEN_W'(1);
    else if (len_raw > LEN_W'(MAX_ROW_BYTES))    len_eff = LEN_W'(MAX_ROW_BYTES);
    else                                         len_eff = len_raw;
  end

  // commit decode
  logic ok, rd_end, commit_wr, commit_rd;
  pix_t sel_res;

  always_comb begin
    ok        = (st_q == ST_OK);
    rd_end    = (rpos >= wpos);
    commit_wr = cmd.commit && ok && wr_q;
    commit_rd = cmd.commit && ok && !wr_q;
    case (chosen)
      FLT_NONE:  sel_res = res_q[0];
      FLT_SUB:   sel_res = res_q[1];
      FLT_UP:    sel_res = res_q[2];
      FLT_AVG:   sel_res = res_q[3];
      FLT_PAETH: sel_res = res_q[4];
      default:   sel_res = '0;
    endcase
  end

  // smallest sum, ties to the lower filter
  logic [FLT_W-1:0] w01, w23, w03, best;
  logic [SUM_W-1:0] s01, s23, s03;

  always_comb begin
    w01  = (sums[1] < sums[0]) ? FLT_SUB : FLT_NONE;
    s01  = (sums[1] < sums[0]) ? sums[1] : sums[0];
    w23  = (sums[3] < sums[2]) ? FLT_AVG : FLT_UP;
    s23  = (sums[3] < sums[2]) ? sums[3] : sums[2];
    w03  = (s23 < s01) ? w23 : w01;
    s03  = (s23 < s01) ? s23 : s01;
    best = (sums[4] < s03) ? FLT_PAETH : w03;
  end

  // row memories
  always_ff @(posedge clk) begin
    if (commit_wr && !bank) mem0[idx_q] <= data_q;
    if (commit_wr && bank)  mem1[idx_q] <= data_q;
    if (cmd.accept) begin
      m0_x <= mem0[rd_i];
      m0_l <= mem0[rd_l];
      m1_x <= mem1[rd_i];
      m1_l <= mem1[rd_l];
    end
  end

  // item and residue registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wr_q     <= is_wr;
      data_q   <= data_byte;
      newimg_q <= new_image;
      idx_q    <= rd_i;
      left_q   <= rd_left;
      hp_q     <= has_prev && !(is_wr && new_image);
      if (is_wr) st_q <= pending ? ST_REFUSED : ST_OK;
      else       st_q <= pending ? ST_OK : ST_NOTHING;
    end
    if (cmd.eval) begin
      for (int f = 0; f < NUM_FILTERS; f++) begin
        res_q[f] <= res[f];
      end
    end
    if (cmd.commit) begin
      status   <= st_q;
      out_byte <= (ok && !wr_q) ? ((rpos == '0) ? 8'(chosen) : sel_res) : '0;
      row_last <= ok && !wr_q && (rpos != '0) && rd_end;
    end
  end

  // row state
  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      has_prev  <= 1'b0;
      pending   <= 1'b0;
      wpos      <= '0;
      rpos      <= '0;
      chosen    <= FLT_NONE;
      res_valid <= 1'b0;
      row_end_q <= 1'b0;
      for (int f = 0; f < NUM_FILTERS; f++) begin
        sums[f] <= '0;
      end
    end else begin
      if (cmd.eval) begin
        row_end_q <= wr_q && (st_q == ST_OK) && (LEN_W'(nxt_pos) >= len_eff);
      end
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.commit) res_valid <= 1'b1;
      if (commit_wr) begin
        if (newimg_q) has_prev <= 1'b0;
        for (int f = 0; f < NUM_FILTERS; f++) begin
          sums[f] <= (newimg_q ? '0 : sums[f]) + SUM_W'(residue_mag(res_q[f]));
        end
        wpos <= nxt_pos;
        if (row_end_q) begin
          pending <= 1'b1;
          rpos    <= '0;
        end
      end
      if (commit_rd) begin
        if (rd_end) begin
          bank     <= ~bank;
          has_prev <= 1'b1;
          wpos     <= '0;
          pending  <= 1'b0;
          rpos     <= '0;
          for (int f = 0; f < NUM_FILTERS; f++) begin
            sums[f] <= '0;
          end
        end else begin
          rpos <= rpos + POS_W'(1);
        end
      end
      if (cmd.select) chosen <= best;
    end
  end

  assign sts.out_busy = res_valid && !res_ready;
  assign sts.row_end  = row_end_q;

endmodule

FILE: rtl/png_adaptive_row_filter.sv
// png_adaptive_row_filter: adaptive png row filter, minimum sum of absolute residues
// depends on paf_pkg, paf_ctrl and paf_datapath; holds the configuration registers
//
// usage: each request on req_valid/req_ready either writes one raw row byte
// (req_type 0, data_byte, new_image) or reads the next output byte (req_type 1).
// every request gives exactly one transfer on res_valid/res_ready carrying
// out_byte, row_last and status. a write that completes a row picks the filter
// with the smallest sum; reads then return the filter type, then the filtered
// row, with row_last on its final byte.
// timing: a request is taken once the sequencer is back in idle after the previous
// commit and any select step; it passes accept with registered row memory reads,
// residue evaluation and commit, plus a select step on the write that ends a row
// for the five-way sum compare. result appears on res_valid the cycle after commit.
// a stalled receiver holds the result in the output register; the next request
// is still accepted and waits in the commit step until the register frees.
// reset clears the sums, the pending flag and the previous-row flag and sets
// row_length and bytes_per_pixel to 1; the row memories are not cleared.
// registers over apb: row_length at 0x0, bytes_per_pixel at 0x4.
module png_adaptive_row_filter #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic        new_image,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  out_byte,
  output logic        row_last,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import paf_pkg::*;

  logic [ROW_LEN_W-1:0] row_length;
  logic [BPP_W-1:0]     bytes_per_pixel;
  paf_cmd_t             cmd;
  paf_sts_t             sts;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length      <= ROW_LEN_W'(1);
      bytes_per_pixel <= BPP_MIN;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROW_LENGTH: row_length      <= pwdata[ROW_LEN_W-1:0];
        REG_BPP:        bytes_per_pixel <= pwdata[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_LENGTH: prdata = 32'(row_length);
      REG_BPP:        prdata = 32'(bytes_per_pixel);
      default:        prdata = '0;
    endcase
  end

  paf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  paf_datapath #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .row_length      (row_length),
    .bytes_per_pixel (bytes_per_pixel),
    .req_type        (req_type),
    .data_byte       (data_byte),
    .new_image       (new_image),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .out_byte        (out_byte),
    .row_last        (row_last),
    .status          (status)
  );

endmodule

FILE: verif/png_adaptive_row_filter_tb.sv
`timescale 1ns / 1ps
// png_adaptive_row_filter_tb: self-checking bench for the adaptive png row filter
// needs paf_pkg and png_adaptive_row_filter; predicts every result from a row model
// held in the bench and compares it on each result transfer
module png_adaptive_row_filter_tb;
  import paf_pkg::*;

  localparam int ROW_CAP = 4096;

  typedef struct packed {
    pix_t       code;
    logic       is_last;
    logic [1:0] status;
  } filt_out_t;

  typedef struct packed {
    logic      kind;
    pix_t      data;
    logic      fresh;
    filt_out_t want;
  } filt_req_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        req_type = REQ_WRITE;
  logic [7:0]  data_byte = 8'h00;
  logic        new_image = 1'b0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        row_last;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  png_adaptive_row_filter #(.MAX_ROW_BYTES(ROW_CAP)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .data_byte(data_byte), .new_image(new_image),
    .res_valid(res_valid), .res_ready(res_ready), .out_byte(out_byte),
    .row_last(row_last), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // row filter model state
  logic [ROW_LEN_W-1:0] len_reg = 1;
  logic [BPP_W-1:0]     bpp_reg = 1;
  pix_t                 raw_row [ROW_CAP];
  pix_t                 up_row [ROW_CAP];
  logic                 up_valid = 1'b0;
  int                   up_len = 0;
  int                   wr_idx = 0;
  int                   rd_idx = 0;
  int                   abs_sums [NUM_FILTERS] = '{0, 0, 0, 0, 0};
  logic [FLT_W-1:0]     pick = FLT_NONE;
  logic                 row_ready = 1'b0;

  filt_req_t req_q[$];
  filt_out_t exp_q[$];
  filt_req_t in_flight;
  filt_out_t seen_want;
  int        total_queued = 0;
  int        total_done = 0;
  int        errors = 0;
  int        send_gap = 0;
  int        send_calm = 0;
  int        recv_gap = 0;
  int        recv_calm = 0;

  function automatic int row_limit();
    if (len_reg == 0) return 1;
    if (len_reg > ROW_CAP) return ROW_CAP;
    return int'(len_reg);
  endfunction

  function automatic int pixel_step();
    if (bpp_reg < BPP_MIN) return int'(BPP_MIN);
    if (bpp_reg > BPP_MAX) return int'(BPP_MAX);
    return int'(bpp_reg);
  endfunction

  function automatic pix_t residual(input logic [FLT_W-1:0] f, input int i);
    int s, a, b, c, p, pa, pb, pc, pr;
    s = pixel_step();
    a = (i >= s) ? int'(raw_row[i - s]) : 0;
    b = up_valid ? int'(up_row[i]) : 0;
    c = (i >= s && up_valid) ? int'(up_row[i - s]) : 0;
    case (f)
      FLT_NONE: pr = 0;
      FLT_SUB:  pr = a;
      FLT_UP:   pr = b;
      FLT_AVG:  pr = (a + b) / 2;
      default: begin
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        pr = (pa <= pb && pa <= pc) ? a : ((pb <= pc) ? b : c);
      end
    endcase
    return pix_t'(int'(raw_row[i]) - pr);
  endfunction

  function automatic filt_out_t filter_step(input logic kind, input pix_t data,
                                            input logic fresh);
    filt_out_t o;
    int pos, k, best;
    pix_t rv;
    o.code = '0;
    o.is_last = 1'b0;
    o.status = ST_OK;
    if (kind == REQ_WRITE) begin
      if (row_ready) begin
        o.status = ST_REFUSED;
        return o;
      end
      if (fresh) begin
        up_valid = 1'b0;
        wr_idx = 0;
        for (k = 0; k < NUM_FILTERS; k++) abs_sums[k] = 0;
      end
      pos = (wr_idx >= ROW_CAP) ? ROW_CAP - 1 : wr_idx;
      raw_row[pos] = data;
      for (k = 0; k < NUM_FILTERS; k++) begin
        rv = residual(FLT_W'(k), pos);
        abs_sums[k] += rv[7] ? 256 - int'(rv) : int'(rv);
      end
      wr_idx = pos + 1;
      if (wr_idx >= row_limit()) begin
        best = 0;
        for (k = 1; k < NUM_FILTERS; k++)
          if (abs_sums[k] < abs_sums[best]) best = k;
        pick = FLT_W'(best);
        row_ready = 1'b1;
        rd_idx = 0;
      end
    end else if (!row_ready) begin
      o.status = ST_NOTHING;
    end else begin
      if (rd_idx == 0) begin
        o.code = pix_t'(pick);
      end else begin
        o.code = residual(pick, rd_idx - 1);
        o.is_last = (rd_idx >= wr_idx);
      end
      if (rd_idx >= wr_idx) begin
        for (k = 0; k < wr_idx; k++) up_row[k] = raw_row[k];
        up_valid = 1'b1;
        up_len = wr_idx;
        wr_idx = 0;
        for (k = 0; k < NUM_FILTERS; k++) abs_sums[k] = 0;
        row_ready = 1'b0;
        rd_idx = 0;
      end else begin
        rd_idx++;
      end
    end
    return o;
  endfunction

  // a row never runs past the previous one: such bytes start a new image
  task automatic queue_req(input logic kind, input pix_t data, input logic fresh);
    filt_req_t item;
    if (kind == REQ_WRITE && !row_ready && up_valid && wr_idx >= up_len) fresh = 1'b1;
    item.kind = kind;
    item.data = data;
    item.fresh = fresh;
    item.want = filter_step(kind, data, fresh);
    req_q.push_back(item);
    total_queued++;
  endtask

  task automatic random_req();
    int r, s, pos;
    pix_t d;
    r = $urandom_range(0, 99);
    s = pixel_step();
    pos = wr_idx;
    if (row_ready) begin
      if (r < 93) queue_req(REQ_READ, pix_t'($urandom), 1'($urandom));
      else queue_req(REQ_WRITE, pix_t'($urandom), 1'($urandom));
    end else if (r < 4) begin
      queue_req(REQ_READ, pix_t'($urandom), 1'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: d = pix_t'($urandom);
        1: d = (pos >= s) ? pix_t'(int'(raw_row[pos - s]) + $urandom_range(0, 6) - 3)
                          : pix_t'($urandom);
        2: d = (up_valid && pos < up_len)
               ? pix_t'(int'(up_row[pos]) + $urandom_range(0, 6) - 3) : pix_t'($urandom);
        default: begin
          d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          if ($urandom_range(0, 1)) d ^= 8'h80;
        end
      endcase
      queue_req(REQ_WRITE, d, r >= 97);
    end
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ROW_LENGTH) len_reg = val[ROW_LEN_W-1:0];
    else bpp_reg = val[BPP_W-1:0];
  endtask

  task automatic settle();
    while (total_done < total_queued) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      if (errors < 100)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) exp_q.push_back(in_flight.want);
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_flight = req_q.pop_front();
          req_valid <= 1'b1;
          req_type <= in_flight.kind;
          data_byte <= in_flight.data;
          new_image <= in_flight.fresh;
          send_gap = idle_len(send_calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        total_done++;
        if (exp_q.size() == 0) begin
          if (errors < 100)
            $display("%0t ns: unexpected transfer, expected none, actual %0h/%0b/%0d",
                     $time, out_byte, row_last, status);
          errors++;
        end else begin
          seen_want = exp_q.pop_front();
          compare_field("out_byte", seen_want.code, out_byte);
          compare_field("row_last", 8'(seen_want.is_last), 8'(row_last));
          compare_field("status", 8'(seen_want.status), 8'(status));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res_ready <= 1'b0;
      end else begin
        recv_gap = idle_len(recv_calm);
        res_ready <= (recv_gap == 0);
        if (recv_gap > 0) recv_gap--;
      end
    end
  end

  initial begin
    int phase, n, len, bpp, random_items;
    logic [31:0] junk;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: one-byte rows
    queue_req(REQ_READ, 8'h00, 1'b0);
    queue_req(REQ_WRITE, 8'hFF, 1'b0);
    queue_req(REQ_WRITE, 8'h12, 1'b1);
    queue_req(REQ_READ, 8'hFF, 1'b1);
    queue_req(REQ_READ, 8'h00, 1'b0);
    settle();

    set_reg(REG_ROW_LENGTH, 32'd4);
    set_reg(REG_BPP, 32'd0);
    queue_req(REQ_WRITE, 8'h80, 1'b1);
    queue_req(REQ_WRITE, 8'h7F, 1'b0);
    queue_req(REQ_WRITE, 8'h00, 1'b0);
    queue_req(REQ_WRITE, 8'hFF, 1'b0);
    repeat (5) queue_req(REQ_READ, 8'h00, 1'b0);
    // new image in the middle of a row
    queue_req(REQ_WRITE, 8'h01, 1'b0);
    queue_req(REQ_WRITE, 8'hFE, 1'b0);
    queue_req(REQ_WRITE, 8'h40, 1'b1);
    queue_req(REQ_WRITE, 8'hC0, 1'b0);
    queue_req(REQ_WRITE, 8'h3F, 1'b0);
    queue_req(REQ_WRITE, 8'hBF, 1'b0);
    repeat (5) queue_req(REQ_READ, 8'h00, 1'b0);
    settle();

    phase = 0;
    random_items = 0;
    while (random_items < 1950) begin
      case (phase)
        0: begin len = 4096; bpp = 4; end
        1: begin len = 3;    bpp = 7; end
        2: begin len = 8191; bpp = 0; end
        3: begin len = 0;    bpp = 1; end
        4: begin len = 1;    bpp = 2; end
        5: begin len = 9;    bpp = 3; end
        default: begin
          case ($urandom_range(0, 9))
            0: len = 0;
            1: len = 1;
            2: len = $urandom_range(4096, 8191);
            3: len = $urandom_range(17, 200);
            default: len = $urandom_range(2, 16);
          endcase
          bpp = $urandom_range(0, 7);
        end
      endcase
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      if (phase < 6 || $urandom_range(0, 1))
        set_reg(REG_ROW_LENGTH, (junk & 32'hFFFF_E000) | 32'(len));
      if (phase < 6 || $urandom_range(0, 1))
        set_reg(REG_BPP, (junk & 32'hFFFF_FFF8) | 32'(bpp));
      if (row_limit() <= 200) n = $urandom_range(20, 120) + 2 * row_limit();
      else n = $urandom_range(20, 60);
      if (n > 1950 - random_items) n = 1950 - random_items;
      repeat (n) random_req();
      random_items += n;
      phase++;
      settle();
    end

    settle();
    if (errors == 0 && exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
